FILE: design/psibc_pkg.sv
// ---------------------------------------------------------------------------
// psibc_pkg: shared constants and types for the per-source IP byte counter
// Holds table sizes, derived widths, outcome codes and the structs that
// travel along the cell chain and the shared write bus.
// ---------------------------------------------------------------------------
package psibc_pkg;

    // Table sizes and chain length
    localparam int V4_ENTRIES = 1024;
    localparam int V6_ENTRIES = 1024;
    localparam int NUM_CELLS  = 8;
    localparam int CELL_W     = $clog2(NUM_CELLS);

    // Rows per cell bank, entry i lives in cell i % NUM_CELLS, row i / NUM_CELLS
    localparam int V4_ROWS   = (V4_ENTRIES + NUM_CELLS - 1) / NUM_CELLS;
    localparam int V6_ROWS   = (V6_ENTRIES + NUM_CELLS - 1) / NUM_CELLS;
    localparam int V4_ROW_W  = (V4_ROWS > 1) ? $clog2(V4_ROWS) : 1;
    localparam int V6_ROW_W  = (V6_ROWS > 1) ? $clog2(V6_ROWS) : 1;
    localparam int ROW_W     = (V4_ROW_W > V6_ROW_W) ? V4_ROW_W : V6_ROW_W;
    localparam int PEAK_ENTRIES = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;
    localparam int CNT_W     = $clog2(PEAK_ENTRIES + 1);
    localparam int CMP_W     = ROW_W + CELL_W + 1;

    // Field widths
    localparam int ETYPE_W   = 16;
    localparam int LEN_W     = 16;
    localparam int ADDR_W    = 64;
    localparam int V4_KEY_W  = 32;
    localparam int TOTAL_W   = 64;
    localparam int V4_WORD_W = V4_KEY_W + TOTAL_W;
    localparam int V6_WORD_W = 2 * ADDR_W + TOTAL_W;
    localparam int CODE_W    = 3;

    // Frame classification
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [LEN_W-1:0]   ETH_HDR_LEN    = 16'd14;
    localparam logic [LEN_W-1:0]   IPV4_MIN_LEN   = 16'd34;
    localparam logic [LEN_W-1:0]   IPV6_MIN_LEN   = 16'd54;

    // Outcome codes
    localparam logic [CODE_W-1:0] OUT_ADDED  = 3'd0;
    localparam logic [CODE_W-1:0] OUT_NEW    = 3'd1;
    localparam logic [CODE_W-1:0] OUT_FULL   = 3'd2;
    localparam logic [CODE_W-1:0] OUT_SHORT  = 3'd3;
    localparam logic [CODE_W-1:0] OUT_NOT_IP = 3'd4;

    // Lookup token handed from cell to cell, one per table row
    typedef struct packed {
        logic                active;
        logic                last;
        logic                is_v6;
        logic [ROW_W-1:0]    row;
        logic [CNT_W-1:0]    count;
        logic [ADDR_W-1:0]   key_hi;
        logic [ADDR_W-1:0]   key_lo;
        logic                hit;
        logic [CELL_W-1:0]   hit_cell;
        logic [TOTAL_W-1:0]  hit_total;
    } t_tok;

    // Table write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic                is_v6;
        logic [CELL_W-1:0]   bank;
        logic [ROW_W-1:0]    row;
        logic [ADDR_W-1:0]   key_hi;
        logic [ADDR_W-1:0]   key_lo;
        logic [TOTAL_W-1:0]  total;
    } t_wr;

endpackage

FILE: design/psibc_cell.sv
// ---------------------------------------------------------------------------
// psibc_cell: one cell of the lookup chain
// Owns one bank of each table (key and total per row). Registers the row named
// by the incoming token, compares the registered entry and hands the token,
// with any hit folded in, to the next cell.
// ---------------------------------------------------------------------------
module psibc_cell import psibc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_cell_id,
    input  t_tok              i_tok,
    input  t_wr               i_wr,
    output t_tok              o_tok
);

    logic [V4_WORD_W-1:0] r_v4_mem [V4_ROWS];
    logic [V6_WORD_W-1:0] r_v6_mem [V6_ROWS];
    logic [V4_WORD_W-1:0] r_v4_rd;
    logic [V6_WORD_W-1:0] r_v6_rd;
    t_tok                 r_tok;

    logic [CMP_W-1:0]     w_idx;
    logic                 w_live;
    logic                 w_match;
    logic [TOTAL_W-1:0]   w_total;

    // Write this cell's bank when the broadcast names it
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.bank == i_cell_id)) begin
            if (i_wr.is_v6) begin
                r_v6_mem[i_wr.row[V6_ROW_W-1:0]] <= {i_wr.key_hi, i_wr.key_lo, i_wr.total};
            end else begin
                r_v4_mem[i_wr.row[V4_ROW_W-1:0]] <= {i_wr.key_lo[V4_KEY_W-1:0], i_wr.total};
            end
        end
    end

    // Read the row of the arriving token
    always_ff @(posedge i_clk) begin
        r_v4_rd <= r_v4_mem[i_tok.row[V4_ROW_W-1:0]];
        r_v6_rd <= r_v6_mem[i_tok.row[V6_ROW_W-1:0]];
    end

    // Hold the token beside its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Compare the entry and fold a hit into the outgoing token
    always_comb begin
        w_idx  = {1'b0, r_tok.row, i_cell_id};
        w_live = w_idx < CMP_W'(r_tok.count);
        if (r_tok.is_v6) begin
            w_match = (r_v6_rd[V6_WORD_W-1 -: 2*ADDR_W] == {r_tok.key_hi, r_tok.key_lo});
            w_total = r_v6_rd[TOTAL_W-1:0];
        end else begin
            w_match = (r_v4_rd[V4_WORD_W-1 -: V4_KEY_W] == r_tok.key_lo[V4_KEY_W-1:0]);
            w_total = r_v4_rd[TOTAL_W-1:0];
        end
        o_tok = r_tok;
        if (r_tok.active && !r_tok.hit && w_live && w_match) begin
            o_tok.hit       = 1'b1;
            o_tok.hit_cell  = i_cell_id;
            o_tok.hit_total = w_total;
        end
    end

endmodule

FILE: design/per_source_ip_byte_counter.sv
// ---------------------------------------------------------------------------
// per_source_ip_byte_counter: byte totals per IPv4 / IPv6 source address
// Classifies each frame summary, looks its source up in an exact-match table
// held across a chain of cells, and adds or allocates its byte total.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one frame summary per
//   transfer. Output channel (o_out_valid / i_out_stall) returns one outcome
//   code and the updated byte total for every frame, in order.
//   Entries are spread over NUM_CELLS cells, entry i in cell i % NUM_CELLS.
//   A lookup streams one table row per cycle into the first cell; each row
//   token walks the chain one cell per cycle. With n entries in use in the
//   selected table, ceil(n / NUM_CELLS) rows are swept, then the chain
//   drains until the last token leaves it and the result is resolved. A
//   short or non-IP frame or an empty table skips the sweep and the drain;
//   one item is in work at a time.
//   The result sits in an output register, so the next frame is taken while
//   a finished result waits. If the receiver stalls, the result holds and the
//   following item waits in its final step until the register frees.
//   Reset empties both tables (fill counts to zero) at once; no clearing pass.
// ---------------------------------------------------------------------------
module per_source_ip_byte_counter import psibc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ETYPE_W-1:0]  i_ether_type,
    input  logic [LEN_W-1:0]    i_frame_length,
    input  logic [ADDR_W-1:0]   i_source_addr_high,
    input  logic [ADDR_W-1:0]   i_source_addr_low,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CODE_W-1:0]   o_outcome,
    output logic [TOTAL_W-1:0]  o_byte_total
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CNT_W-1:0]    r_v4_cnt;
    logic [CNT_W-1:0]    r_v6_cnt;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    r_row_last;
    logic                r_is_v6;
    logic                r_counted;
    logic [CODE_W-1:0]   r_code;
    logic [LEN_W-1:0]    r_len;
    logic [ADDR_W-1:0]   r_key_hi;
    logic [ADDR_W-1:0]   r_key_lo;
    logic                r_hit;
    logic [CELL_W-1:0]   r_hit_cell;
    logic [ROW_W-1:0]    r_hit_row;
    logic [TOTAL_W-1:0]  r_hit_total;
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_out_code;
    logic [TOTAL_W-1:0]  r_out_total;

    logic                w_accept;
    logic                w_in_v4;
    logic                w_in_v6;
    logic                w_in_counted;
    logic [CODE_W-1:0]   w_in_code;
    logic [CNT_W-1:0]    w_acc_cnt;
    logic [CMP_W-1:0]    w_rows_sum;
    logic [CMP_W-1:0]    w_rows;
    logic [CNT_W-1:0]    w_sel_cnt;
    logic                w_full;
    logic [CMP_W-1:0]    w_new_pos;
    logic                w_out_free;
    logic                w_finish;
    logic [CODE_W-1:0]   w_res_code;
    logic [TOTAL_W-1:0]  w_res_total;
    logic [TOTAL_W-1:0]  w_sum;
    t_tok                w_head;
    t_tok                w_tail;
    t_wr                 w_wr;
    t_tok                w_chain [NUM_CELLS+1];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_out_code;
    assign o_byte_total = r_out_total;

    // Classify the incoming frame
    always_comb begin
        w_in_v4      = (i_ether_type == ETHERTYPE_IPV4);
        w_in_v6      = (i_ether_type == ETHERTYPE_IPV6);
        w_in_counted = 1'b0;
        w_in_code    = OUT_NOT_IP;
        if (i_frame_length < ETH_HDR_LEN) begin
            w_in_code = OUT_SHORT;
        end else if (w_in_v4) begin
            if (i_frame_length < IPV4_MIN_LEN) begin
                w_in_code = OUT_SHORT;
            end else begin
                w_in_counted = 1'b1;
            end
        end else if (w_in_v6) begin
            if (i_frame_length < IPV6_MIN_LEN) begin
                w_in_code = OUT_SHORT;
            end else begin
                w_in_counted = 1'b1;
            end
        end
        w_acc_cnt  = w_in_v6 ? r_v6_cnt : r_v4_cnt;
        w_rows_sum = CMP_W'(w_acc_cnt) + CMP_W'(NUM_CELLS - 1);
        w_rows     = w_rows_sum >> CELL_W;
    end

    // Feed one row token per cycle into the chain during the sweep
    always_comb begin
        w_head           = '0;
        w_head.active    = (r_state == ST_SWEEP);
        w_head.last      = (r_row == r_row_last);
        w_head.is_v6     = r_is_v6;
        w_head.row       = r_row;
        w_head.count     = w_sel_cnt;
        w_head.key_hi    = r_key_hi;
        w_head.key_lo    = r_key_lo;
    end

    assign w_chain[0] = w_head;

    // Cell chain
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        psibc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(k)),
            .i_tok     (w_chain[k]),
            .i_wr      (w_wr),
            .o_tok     (w_chain[k+1])
        );
    end

    assign w_tail = w_chain[NUM_CELLS];

    // Resolve the outcome and the table write
    always_comb begin
        w_sel_cnt  = r_is_v6 ? r_v6_cnt : r_v4_cnt;
        w_full     = r_is_v6 ? (r_v6_cnt == CNT_W'(V6_ENTRIES))
                             : (r_v4_cnt == CNT_W'(V4_ENTRIES));
        w_new_pos  = CMP_W'(w_sel_cnt);
        w_sum      = r_hit_total + TOTAL_W'(r_len);
        w_out_free = !r_out_valid || !i_out_stall;
        w_finish   = (r_state == ST_DONE) && w_out_free;

        w_res_code  = r_code;
        w_res_total = '0;
        if (r_counted) begin
            if (r_hit) begin
                w_res_code  = OUT_ADDED;
                w_res_total = w_sum;
            end else if (w_full) begin
                w_res_code  = OUT_FULL;
            end else begin
                w_res_code  = OUT_NEW;
                w_res_total = TOTAL_W'(r_len);
            end
        end

        w_wr        = '0;
        w_wr.en     = w_finish && r_counted && (r_hit || !w_full);
        w_wr.is_v6  = r_is_v6;
        w_wr.key_hi = r_key_hi;
        w_wr.key_lo = r_key_lo;
        w_wr.total  = w_res_total;
        if (r_hit) begin
            w_wr.bank = r_hit_cell;
            w_wr.row  = r_hit_row;
        end else begin
            w_wr.bank = w_new_pos[CELL_W-1:0];
            w_wr.row  = w_new_pos[CELL_W +: ROW_W];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_counted && (w_rows != '0)) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_row == r_row_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_tail.active && w_tail.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, fill counts, hit flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v4_cnt    <= '0;
            r_v6_cnt    <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_hit <= 1'b0;
            end else if ((r_state == ST_SWEEP || r_state == ST_DRAIN)
                         && w_tail.active && w_tail.hit) begin
                r_hit <= 1'b1;
            end
            if (w_wr.en && !r_hit) begin
                if (r_is_v6) begin
                    r_v6_cnt <= r_v6_cnt + CNT_W'(1);
                end else begin
                    r_v4_cnt <= r_v4_cnt + CNT_W'(1);
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, row sweep, hit capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_v6    <= w_in_v6;
            r_counted  <= w_in_counted;
            r_code     <= w_in_code;
            r_len      <= i_frame_length;
            r_key_hi   <= i_source_addr_high;
            r_key_lo   <= i_source_addr_low;
            r_row      <= '0;
            r_row_last <= w_rows[ROW_W-1:0] - ROW_W'(1);
        end else if (r_state == ST_SWEEP) begin
            r_row <= r_row + ROW_W'(1);
        end
        if ((r_state == ST_SWEEP || r_state == ST_DRAIN) && w_tail.active && w_tail.hit) begin
            r_hit_cell  <= w_tail.hit_cell;
            r_hit_row   <= w_tail.row;
            r_hit_total <= w_tail.hit_total;
        end
        if (w_finish) begin
            r_out_code  <= w_res_code;
            r_out_total <= w_res_total;
        end
    end

endmodule
